>>> hdl/kvt_pkg.sv
// Shared types, constants and command/status codes of the key/value table.
`timescale 1ns / 1ps
`default_nettype none
package kvt_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CAP_W       = 6;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_QUERY  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_ZERO   = 2'd3;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);
	localparam logic [CAP_W-1:0] LIM_MAX   = CAP_W'(TABLE_DEPTH);

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] key;
		logic [31:0] new_value;
	} kvt_cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [31:0]      found_value;
		logic [4:0]       entry_count;
		logic [CAP_W-1:0] capacity_now;
	} kvt_result_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] value;
	} kvt_entry_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic wrap;
	} kvt_ctl_t;

endpackage
`default_nettype wire

>>> hdl/terminated_key_value_table_top.sv
// Top level of the key/value table: command sequencer and the row of table cells.
//
// Usage:
//   A command (append, look up, remove, query) is taken on cmd at a clock edge
//   where start is high and busy is low. Exactly one result follows on result,
//   valid for one cycle while done is high; the receiver cannot stall it.
//   Append and query answer in the cycle after the command is taken and keep
//   busy low. Look up and remove rotate the stored entries once through the
//   head cell of the row, one entry per cycle, and hold busy while they do; they
//   answer with done in the cycle after the last step. On an empty table they
//   answer in the cycle after the command is taken.
//   The capacity register is written over cfg_valid/cfg_ready/cfg_data; the
//   port is ready whenever no command is in progress or offered on start.
//   Reset empties the table and sets the capacity to 32; no sweep is needed,
//   since cells above the fill are never read before an append writes them.
`timescale 1ns / 1ps
`default_nettype none
module terminated_key_value_table_top import kvt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire kvt_cmd_t          cmd,
	output logic                   busy,
	output logic                   done,
	output kvt_result_t            result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CAP_W-1:0]  cfg_data
);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t           state_q;
	logic             done_q;
	kvt_result_t      result_q;
	kvt_cmd_t         cmd_q;
	logic [IDX_W-1:0] fill_q;
	logic [IDX_W-1:0] step_q;
	logic [IDX_W-1:0] last_q;
	logic             found_q;
	logic [31:0]      value_q;
	logic [CAP_W-1:0] cap_q;

	kvt_entry_t       cells [TABLE_DEPTH];
	kvt_entry_t       new_entry;
	kvt_entry_t       head;
	kvt_entry_t       zero_entry;
	logic [CAP_W-1:0] lim;
	logic [CAP_W-1:0] fill_ext;
	logic [1:0]       app_status;
	logic             accept;
	logic             append_ok;
	logic             hit;
	logic             drop;
	logic             found_any;
	logic [IDX_W-1:0] tail_idx;

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = !busy && !start;

	assign accept     = start && !busy;
	assign new_entry  = '{key: cmd.key, value: cmd.new_value};
	assign zero_entry = '0;
	assign head       = cells[0];
	assign tail_idx   = fill_q - 1'b1;
	assign fill_ext   = CAP_W'(fill_q);
	assign lim        = (cap_q > LIM_MAX) ? LIM_MAX : cap_q;

	always_comb begin
		if (cmd.key == '0) begin
			app_status = ST_ZERO;
		end else if (lim == '0 || fill_ext >= lim - 1'b1) begin
			app_status = ST_FULL;
		end else begin
			app_status = ST_OK;
		end
	end

	assign append_ok = accept && cmd.command == CMD_APPEND && app_status == ST_OK;
	assign hit       = state_q == S_SCAN && !found_q && cmd_q.key != '0 &&
		head.key == cmd_q.key;
	assign drop      = hit && cmd_q.command == CMD_REMOVE;
	assign found_any = found_q || hit;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(i);
		kvt_ctl_t   ctl;
		kvt_entry_t right;

		assign ctl = '{
			load:  append_ok && fill_q == CELL_IDX,
			shift: state_q == S_SCAN,
			wrap:  !drop && tail_idx == CELL_IDX
		};

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign right = zero_entry;
		end else begin : g_mid
			assign right = cells[i+1];
		end

		kvt_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_entry (new_entry),
			.right     (right),
			.head      (head),
			.entry     (cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
			cmd_q    <= '0;
			fill_q   <= '0;
			step_q   <= '0;
			last_q   <= '0;
			found_q  <= 1'b0;
			value_q  <= '0;
			cap_q    <= CAP_RESET;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						result_q.found_value  <= '0;
						result_q.capacity_now <= cap_q;
						result_q.entry_count  <= fill_q;
						case (cmd.command)
							CMD_APPEND: begin
								done_q          <= 1'b1;
								result_q.status <= app_status;
								if (app_status == ST_OK) begin
									fill_q               <= fill_q + 1'b1;
									result_q.entry_count <= fill_q + 1'b1;
								end
							end
							CMD_LOOKUP, CMD_REMOVE: begin
								if (fill_q == '0) begin
									done_q          <= 1'b1;
									result_q.status <= ST_ABSENT;
								end else begin
									state_q <= S_SCAN;
									cmd_q   <= cmd;
									step_q  <= '0;
									last_q  <= fill_q - 1'b1;
									found_q <= 1'b0;
									value_q <= '0;
								end
							end
							default: begin
								done_q          <= 1'b1;
								result_q.status <= ST_OK;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
						value_q <= head.value;
					end
					if (drop) begin
						fill_q <= fill_q - 1'b1;
					end
					if (step_q == last_q) begin
						state_q               <= S_IDLE;
						done_q                <= 1'b1;
						result_q.status       <= found_any ? ST_OK : ST_ABSENT;
						result_q.capacity_now <= cap_q;
						result_q.entry_count  <= drop ? fill_q - 1'b1 : fill_q;
						if (cmd_q.command == CMD_LOOKUP && found_any) begin
							result_q.found_value <= hit ? head.value : value_q;
						end else begin
							result_q.found_value <= '0;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a command is in progress");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> fill_q != '0)
		else $error("scan running on an empty table");

	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.found_value != '0) |-> result.status == ST_OK)
		else $error("value returned with a failing status");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("scan began without a command");
`endif

endmodule
`default_nettype wire

>>> hdl/kvt_cell.sv
// One slot of the table: holds a key/value pair and passes it toward the head.
`timescale 1ns / 1ps
`default_nettype none
module kvt_cell import kvt_pkg::*; (
	input  wire logic       clk,
	input  wire kvt_ctl_t   ctl,
	input  wire kvt_entry_t new_entry,
	input  wire kvt_entry_t right,
	input  wire kvt_entry_t head,
	output kvt_entry_t      entry
);

	kvt_entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= new_entry;
		end else if (ctl.shift) begin
			entry_q <= ctl.wrap ? head : right;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire
